// File: rtl/indexed_binary_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Indexed binary heap queue - assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define IBHQ_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("ibhq: same-cycle check failed");

// next-cycle implication, off while reset is held
`define IBHQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("ibhq: next-cycle check failed");

`endif

// File: rtl/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// ibhq_pkg
// Types and constants shared by the indexed binary heap queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibhq_pkg;

    localparam int HANDLE_W      = 10;
    localparam int NUM_HANDLES   = 1024;
    localparam int KEY_PORT_W    = 32;
    localparam int COUNT_PORT_W  = 11;
    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_FAIL,
        CMD_INSERT,
        CMD_UPDATE,
        CMD_LOOKUP,
        CMD_POP,
        CMD_TAKE,
        CMD_READ_LAST,
        CMD_LOAD_CUR,
        CMD_READ_PARENT,
        CMD_MOVE_UP,
        CMD_READ_LEFT,
        CMD_BEST_LEFT,
        CMD_BEST_LEFT_RD_RIGHT,
        CMD_BEST_RIGHT,
        CMD_MOVE_DOWN,
        CMD_PLACE,
        CMD_READ_TOP,
        CMD_EMIT
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_TAKE,
        S_FILL,
        S_LAST,
        S_UP,
        S_UPC,
        S_DN,
        S_DNL,
        S_DNR,
        S_DNC,
        S_PLACE,
        S_TOP,
        S_RES
    } t_state;

    typedef struct packed {
        t_cmd    cmd;
        t_status code;
    } t_ctrl;

    typedef struct packed {
        logic clr_done;
        logic present;
        logic empty;
        logic full;
        t_op  op;
        logic at_root;
        logic up_stop;
        logic left_in;
        logic right_in;
        logic right_wins;
        logic down_stop;
        logic fill_needed;
        logic out_free;
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/ibhq_ram.sv
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/ibhq_ctrl.sv
// ----------------------------------------------------------------------------
// ibhq_ctrl
// Sequencer for the heap: clearing pass, op decode, sift up and sift down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibhq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire ibhq_pkg::t_flags i_flags,
    output logic                 o_in_stall,
    output ibhq_pkg::t_ctrl      o_ctrl
);

    ibhq_pkg::t_state r_state;
    ibhq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibhq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ibhq_pkg::S_CLEAR: begin
                if (i_flags.clr_done) n_state = ibhq_pkg::S_IDLE;
            end
            ibhq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ibhq_pkg::S_CHECK;
            end
            ibhq_pkg::S_CHECK: begin
                unique case (i_flags.op)
                    ibhq_pkg::OP_INSERT: begin
                        if (i_flags.present || i_flags.full) n_state = ibhq_pkg::S_RES;
                        else n_state = ibhq_pkg::S_UP;
                    end
                    ibhq_pkg::OP_POP: begin
                        if (i_flags.empty) n_state = ibhq_pkg::S_RES;
                        else n_state = ibhq_pkg::S_TAKE;
                    end
                    ibhq_pkg::OP_REMOVE: begin
                        if (!i_flags.present) n_state = ibhq_pkg::S_RES;
                        else n_state = ibhq_pkg::S_TAKE;
                    end
                    default: begin
                        if (!i_flags.present) n_state = ibhq_pkg::S_RES;
                        else n_state = ibhq_pkg::S_UP;
                    end
                endcase
            end
            ibhq_pkg::S_TAKE:  n_state = ibhq_pkg::S_FILL;
            ibhq_pkg::S_FILL: begin
                n_state = i_flags.fill_needed ? ibhq_pkg::S_LAST : ibhq_pkg::S_TOP;
            end
            ibhq_pkg::S_LAST:  n_state = ibhq_pkg::S_UP;
            ibhq_pkg::S_UP: begin
                n_state = i_flags.at_root ? ibhq_pkg::S_DN : ibhq_pkg::S_UPC;
            end
            ibhq_pkg::S_UPC: begin
                n_state = i_flags.up_stop ? ibhq_pkg::S_DN : ibhq_pkg::S_UP;
            end
            ibhq_pkg::S_DN: begin
                n_state = i_flags.left_in ? ibhq_pkg::S_DNL : ibhq_pkg::S_PLACE;
            end
            ibhq_pkg::S_DNL: begin
                n_state = i_flags.right_in ? ibhq_pkg::S_DNR : ibhq_pkg::S_DNC;
            end
            ibhq_pkg::S_DNR:   n_state = ibhq_pkg::S_DNC;
            ibhq_pkg::S_DNC: begin
                n_state = i_flags.down_stop ? ibhq_pkg::S_PLACE : ibhq_pkg::S_DN;
            end
            ibhq_pkg::S_PLACE: n_state = ibhq_pkg::S_TOP;
            ibhq_pkg::S_TOP:   n_state = ibhq_pkg::S_RES;
            ibhq_pkg::S_RES: begin
                if (i_flags.out_free) n_state = ibhq_pkg::S_IDLE;
            end
            default: n_state = ibhq_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl.cmd  = ibhq_pkg::CMD_NOP;
        o_ctrl.code = ibhq_pkg::ST_OK;
        o_in_stall  = (r_state != ibhq_pkg::S_IDLE);
        unique case (r_state)
            ibhq_pkg::S_CLEAR: o_ctrl.cmd = ibhq_pkg::CMD_CLEAR;
            ibhq_pkg::S_IDLE: begin
                if (i_in_valid) o_ctrl.cmd = ibhq_pkg::CMD_ACCEPT;
            end
            ibhq_pkg::S_CHECK: begin
                unique case (i_flags.op)
                    ibhq_pkg::OP_INSERT: begin
                        if (i_flags.present) begin
                            o_ctrl.cmd  = ibhq_pkg::CMD_FAIL;
                            o_ctrl.code = ibhq_pkg::ST_BAD;
                        end else if (i_flags.full) begin
                            o_ctrl.cmd  = ibhq_pkg::CMD_FAIL;
                            o_ctrl.code = ibhq_pkg::ST_FULL;
                        end else begin
                            o_ctrl.cmd = ibhq_pkg::CMD_INSERT;
                        end
                    end
                    ibhq_pkg::OP_POP: begin
                        if (i_flags.empty) begin
                            o_ctrl.cmd  = ibhq_pkg::CMD_FAIL;
                            o_ctrl.code = ibhq_pkg::ST_EMPTY;
                        end else begin
                            o_ctrl.cmd = ibhq_pkg::CMD_POP;
                        end
                    end
                    ibhq_pkg::OP_REMOVE: begin
                        if (!i_flags.present) begin
                            o_ctrl.cmd  = ibhq_pkg::CMD_FAIL;
                            o_ctrl.code = ibhq_pkg::ST_BAD;
                        end else begin
                            o_ctrl.cmd = ibhq_pkg::CMD_LOOKUP;
                        end
                    end
                    default: begin
                        if (!i_flags.present) begin
                            o_ctrl.cmd  = ibhq_pkg::CMD_FAIL;
                            o_ctrl.code = ibhq_pkg::ST_BAD;
                        end else begin
                            o_ctrl.cmd = ibhq_pkg::CMD_UPDATE;
                        end
                    end
                endcase
            end
            ibhq_pkg::S_TAKE: o_ctrl.cmd = ibhq_pkg::CMD_TAKE;
            ibhq_pkg::S_FILL: begin
                if (i_flags.fill_needed) o_ctrl.cmd = ibhq_pkg::CMD_READ_LAST;
            end
            ibhq_pkg::S_LAST: o_ctrl.cmd = ibhq_pkg::CMD_LOAD_CUR;
            ibhq_pkg::S_UP: begin
                if (!i_flags.at_root) o_ctrl.cmd = ibhq_pkg::CMD_READ_PARENT;
            end
            ibhq_pkg::S_UPC: begin
                if (!i_flags.up_stop) o_ctrl.cmd = ibhq_pkg::CMD_MOVE_UP;
            end
            ibhq_pkg::S_DN: begin
                if (i_flags.left_in) o_ctrl.cmd = ibhq_pkg::CMD_READ_LEFT;
            end
            ibhq_pkg::S_DNL: begin
                o_ctrl.cmd = i_flags.right_in ? ibhq_pkg::CMD_BEST_LEFT_RD_RIGHT
                                              : ibhq_pkg::CMD_BEST_LEFT;
            end
            ibhq_pkg::S_DNR: begin
                if (i_flags.right_wins) o_ctrl.cmd = ibhq_pkg::CMD_BEST_RIGHT;
            end
            ibhq_pkg::S_DNC: begin
                if (!i_flags.down_stop) o_ctrl.cmd = ibhq_pkg::CMD_MOVE_DOWN;
            end
            ibhq_pkg::S_PLACE: o_ctrl.cmd = ibhq_pkg::CMD_PLACE;
            ibhq_pkg::S_TOP:   o_ctrl.cmd = ibhq_pkg::CMD_READ_TOP;
            ibhq_pkg::S_RES: begin
                if (i_flags.out_free) o_ctrl.cmd = ibhq_pkg::CMD_EMIT;
            end
            default: o_ctrl.cmd = ibhq_pkg::CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ibhq_dp.sv
// ----------------------------------------------------------------------------
// ibhq_dp
// Heap datapath: slot and handle-table memories, sift registers, result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibhq_dp #(
    parameter int CAPACITY  = ibhq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibhq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ibhq_pkg::t_ctrl                   i_ctrl,
    input  wire logic                              i_min_mode,
    input  wire logic [1:0]                        i_op,
    input  wire logic [ibhq_pkg::HANDLE_W-1:0]     i_handle,
    input  wire logic [ibhq_pkg::KEY_PORT_W-1:0]   i_key,
    input  wire logic                              i_out_stall,
    output ibhq_pkg::t_flags                       o_flags,
    output logic                                   o_out_valid,
    output logic [1:0]                             o_status,
    output logic [ibhq_pkg::HANDLE_W-1:0]          o_out_handle,
    output logic [ibhq_pkg::KEY_PORT_W-1:0]        o_out_key,
    output logic [ibhq_pkg::COUNT_PORT_W-1:0]      o_count,
    output logic                                   o_top_valid,
    output logic [ibhq_pkg::HANDLE_W-1:0]          o_top_handle,
    output logic [ibhq_pkg::KEY_PORT_W-1:0]        o_top_key
);

    localparam int SW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = SW + 2;
    localparam int HW  = ibhq_pkg::HANDLE_W;
    localparam int KW  = KEY_WIDTH;
    localparam int SLW = KW + HW;
    localparam int TW  = SW + 1;
    localparam int TAW = $clog2(ibhq_pkg::NUM_HANDLES);

    function automatic logic stays_above(input logic mode, input logic [KW-1:0] a,
                                         input logic [KW-1:0] b);
        stays_above = mode ? (a <= b) : (a >= b);
    endfunction

    ibhq_pkg::t_op       r_op;
    logic [HW-1:0]       r_h;
    logic [KW-1:0]       r_k;
    logic [CW-1:0]       r_count;
    logic [SW-1:0]       r_pos;
    logic [KW-1:0]       r_cur_k;
    logic [HW-1:0]       r_cur_h;
    logic [KW-1:0]       r_best_k;
    logic [HW-1:0]       r_best_h;
    logic [SW-1:0]       r_bidx;
    logic [TAW-1:0]      r_clr_addr;
    ibhq_pkg::t_status   r_res_status;
    logic [HW-1:0]       r_res_h;
    logic [KW-1:0]       r_res_k;
    logic                r_out_valid;
    ibhq_pkg::t_status   r_o_status;
    logic [HW-1:0]       r_o_h;
    logic [ibhq_pkg::KEY_PORT_W-1:0]   r_o_k;
    logic [ibhq_pkg::COUNT_PORT_W-1:0] r_o_count;
    logic                r_o_top_valid;
    logic [HW-1:0]       r_o_top_h;
    logic [ibhq_pkg::KEY_PORT_W-1:0]   r_o_top_k;

    logic           slot_we, slot_re;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic [SLW-1:0] slot_wdata, slot_rdata;
    logic           tbl_we, tbl_re;
    logic [TAW-1:0] tbl_waddr, tbl_raddr;
    logic [TW-1:0]  tbl_wdata, tbl_rdata;

    logic [KW-1:0]  w_rd_k;
    logic [HW-1:0]  w_rd_h;
    logic           w_tbl_present;
    logic [SW-1:0]  w_tbl_pos;
    logic [IW-1:0]  w_child;
    logic [IW-1:0]  w_right;
    logic [SW-1:0]  w_parent;
    logic           w_out_free;

    assign w_rd_k        = slot_rdata[SLW-1:HW];
    assign w_rd_h        = slot_rdata[HW-1:0];
    assign w_tbl_present = tbl_rdata[SW];
    assign w_tbl_pos     = tbl_rdata[SW-1:0];
    assign w_child       = IW'({r_pos, 1'b1});
    assign w_right       = w_child + IW'(1);
    assign w_parent      = (r_pos - SW'(1)) >> 1;
    assign w_out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        o_flags.clr_done    = (r_clr_addr == {TAW{1'b1}});
        o_flags.present     = w_tbl_present;
        o_flags.empty       = (r_count == '0);
        o_flags.full        = (r_count == CW'(CAPACITY));
        o_flags.op          = r_op;
        o_flags.at_root     = (r_pos == '0);
        o_flags.up_stop     = stays_above(i_min_mode, w_rd_k, r_cur_k);
        o_flags.left_in     = (w_child < IW'(r_count));
        o_flags.right_in    = (w_right < IW'(r_count));
        o_flags.right_wins  = stays_above(i_min_mode, w_rd_k, r_best_k);
        o_flags.down_stop   = stays_above(i_min_mode, r_cur_k, r_best_k);
        o_flags.fill_needed = (CW'(r_pos) < r_count);
        o_flags.out_free    = w_out_free;
    end

    // memory port steering
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = '0;
        tbl_we     = 1'b0;
        tbl_waddr  = '0;
        tbl_wdata  = '0;
        tbl_re     = 1'b0;
        tbl_raddr  = '0;
        case (i_ctrl.cmd)
            ibhq_pkg::CMD_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr_addr;
            end
            ibhq_pkg::CMD_ACCEPT: begin
                tbl_re    = 1'b1;
                tbl_raddr = i_handle;
                slot_re   = 1'b1;
            end
            ibhq_pkg::CMD_LOOKUP: begin
                slot_re    = 1'b1;
                slot_raddr = w_tbl_pos;
            end
            ibhq_pkg::CMD_TAKE: begin
                tbl_we    = 1'b1;
                tbl_waddr = w_rd_h;
            end
            ibhq_pkg::CMD_READ_LAST: begin
                slot_re    = 1'b1;
                slot_raddr = r_count[SW-1:0];
            end
            ibhq_pkg::CMD_READ_PARENT: begin
                slot_re    = 1'b1;
                slot_raddr = w_parent;
            end
            ibhq_pkg::CMD_MOVE_UP: begin
                slot_we    = 1'b1;
                slot_waddr = r_pos;
                slot_wdata = slot_rdata;
                tbl_we     = 1'b1;
                tbl_waddr  = w_rd_h;
                tbl_wdata  = {1'b1, r_pos};
            end
            ibhq_pkg::CMD_READ_LEFT: begin
                slot_re    = 1'b1;
                slot_raddr = w_child[SW-1:0];
            end
            ibhq_pkg::CMD_BEST_LEFT_RD_RIGHT: begin
                slot_re    = 1'b1;
                slot_raddr = w_right[SW-1:0];
            end
            ibhq_pkg::CMD_MOVE_DOWN: begin
                slot_we    = 1'b1;
                slot_waddr = r_pos;
                slot_wdata = {r_best_k, r_best_h};
                tbl_we     = 1'b1;
                tbl_waddr  = r_best_h;
                tbl_wdata  = {1'b1, r_pos};
            end
            ibhq_pkg::CMD_PLACE: begin
                slot_we    = 1'b1;
                slot_waddr = r_pos;
                slot_wdata = {r_cur_k, r_cur_h};
                tbl_we     = 1'b1;
                tbl_waddr  = r_cur_h;
                tbl_wdata  = {1'b1, r_pos};
            end
            ibhq_pkg::CMD_READ_TOP: begin
                slot_re = 1'b1;
            end
            default: begin
                slot_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.cmd == ibhq_pkg::CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.cmd)
                ibhq_pkg::CMD_CLEAR:  r_clr_addr  <= r_clr_addr + TAW'(1);
                ibhq_pkg::CMD_INSERT: r_count     <= r_count + CW'(1);
                ibhq_pkg::CMD_TAKE:   r_count     <= r_count - CW'(1);
                default:              r_clr_addr  <= r_clr_addr;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            ibhq_pkg::CMD_ACCEPT: begin
                r_op         <= ibhq_pkg::t_op'(i_op);
                r_h          <= i_handle;
                r_k          <= KW'(i_key);
                r_res_status <= ibhq_pkg::ST_OK;
                r_res_h      <= i_handle;
                r_res_k      <= '0;
            end
            ibhq_pkg::CMD_FAIL: begin
                r_res_status <= i_ctrl.code;
                if (i_ctrl.code == ibhq_pkg::ST_EMPTY) r_res_h <= '0;
            end
            ibhq_pkg::CMD_INSERT: begin
                r_pos   <= r_count[SW-1:0];
                r_cur_k <= r_k;
                r_cur_h <= r_h;
                r_res_k <= r_k;
            end
            ibhq_pkg::CMD_UPDATE: begin
                r_pos   <= w_tbl_pos;
                r_cur_k <= r_k;
                r_cur_h <= r_h;
                r_res_k <= r_k;
            end
            ibhq_pkg::CMD_LOOKUP:   r_pos <= w_tbl_pos;
            ibhq_pkg::CMD_POP:      r_pos <= '0;
            ibhq_pkg::CMD_TAKE: begin
                r_res_h <= w_rd_h;
                r_res_k <= w_rd_k;
            end
            ibhq_pkg::CMD_LOAD_CUR: begin
                r_cur_k <= w_rd_k;
                r_cur_h <= w_rd_h;
            end
            ibhq_pkg::CMD_MOVE_UP:  r_pos <= w_parent;
            ibhq_pkg::CMD_BEST_LEFT, ibhq_pkg::CMD_BEST_LEFT_RD_RIGHT: begin
                r_best_k <= w_rd_k;
                r_best_h <= w_rd_h;
                r_bidx   <= w_child[SW-1:0];
            end
            ibhq_pkg::CMD_BEST_RIGHT: begin
                r_best_k <= w_rd_k;
                r_best_h <= w_rd_h;
                r_bidx   <= w_right[SW-1:0];
            end
            ibhq_pkg::CMD_MOVE_DOWN: r_pos <= r_bidx;
            ibhq_pkg::CMD_EMIT: begin
                r_o_status    <= r_res_status;
                r_o_h         <= r_res_h;
                r_o_k         <= ibhq_pkg::KEY_PORT_W'(r_res_k);
                r_o_count     <= ibhq_pkg::COUNT_PORT_W'(r_count);
                r_o_top_valid <= (r_count != '0);
                r_o_top_h     <= (r_count != '0) ? w_rd_h : '0;
                r_o_top_k     <= (r_count != '0) ? ibhq_pkg::KEY_PORT_W'(w_rd_k) : '0;
            end
            default: r_pos <= r_pos;
        endcase
    end

    ibhq_ram #(
        .WIDTH (SLW),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ibhq_ram #(
        .WIDTH (TW),
        .DEPTH (ibhq_pkg::NUM_HANDLES)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_out_handle = r_o_h;
    assign o_out_key    = r_o_k;
    assign o_count      = r_o_count;
    assign o_top_valid  = r_o_top_valid;
    assign o_top_handle = r_o_top_h;
    assign o_top_key    = r_o_top_k;

endmodule

`default_nettype wire

// File: rtl/indexed_binary_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue
// Indexed min/max binary heap with a handle-to-slot table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_op, i_handle, i_key
//  out     | output    | o_out_valid / i_out_stall | o_status .. o_top_key
//  cfg     | input     | i_cfg_we                  | i_cfg_data (min_mode)
//
//  One item at a time: accept and decode, then place, top read and result,
//  with take and refill added for a removal and the sift-up and sift-down
//  steps run in between; an error item goes from decode to the result.
//  After reset a clearing pass marks every handle absent; the input stays
//  stalled during it, configuration writes are taken.
//  The result register lets the next item enter while a result waits on stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_binary_heap_queue_defines.svh"

module indexed_binary_heap_queue #(
    parameter int CAPACITY  = ibhq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibhq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_op,
    input  wire logic [ibhq_pkg::HANDLE_W-1:0]     i_handle,
    input  wire logic [ibhq_pkg::KEY_PORT_W-1:0]   i_key,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_status,
    output logic [ibhq_pkg::HANDLE_W-1:0]          o_out_handle,
    output logic [ibhq_pkg::KEY_PORT_W-1:0]        o_out_key,
    output logic [ibhq_pkg::COUNT_PORT_W-1:0]      o_count,
    output logic                                   o_top_valid,
    output logic [ibhq_pkg::HANDLE_W-1:0]          o_top_handle,
    output logic [ibhq_pkg::KEY_PORT_W-1:0]        o_top_key
);

    // heap order: 1 keeps the smallest key on top
    logic r_min_mode;

    ibhq_pkg::t_ctrl  w_ctrl;
    ibhq_pkg::t_flags w_flags;

    // terms for the checks below
    logic w_top_agrees;
    logic w_res_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_min_mode <= i_cfg_data;
        end
    end

    // sequencer: decodes the op and walks the sift loops
    ibhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (w_flags),
        .o_in_stall (o_in_stall),
        .o_ctrl     (w_ctrl)
    );

    // memories, sift registers and the result stage
    ibhq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_min_mode   (r_min_mode),
        .i_op         (i_op),
        .i_handle     (i_handle),
        .i_key        (i_key),
        .i_out_stall  (i_out_stall),
        .o_flags      (w_flags),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_out_handle (o_out_handle),
        .o_out_key    (o_out_key),
        .o_count      (o_count),
        .o_top_valid  (o_top_valid),
        .o_top_handle (o_top_handle),
        .o_top_key    (o_top_key)
    );

    assign w_top_agrees = (o_top_valid == (o_count != '0));
    assign w_res_empty  = o_out_valid && (o_status == ibhq_pkg::ST_EMPTY);

    // a result shows a top exactly when the heap is non-empty
    `IBHQ_ASSERT_SAME(a_top_matches_count, i_clk, i_rst_n, o_out_valid, w_top_agrees)
    // a pop on an empty heap leaves it empty
    `IBHQ_ASSERT_SAME(a_empty_has_no_items, i_clk, i_rst_n, w_res_empty, o_count == '0)
    // an accepted item closes the input until it is done
    `IBHQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

`default_nettype wire
